>>> sv/iit_pkg.sv
// ----------------------------------------------------------------------------
// iit_pkg: shared types for the integral image table
// Transaction payloads, queued job format, frame dimensions and the codes
// used by the front end and the back end.
// ----------------------------------------------------------------------------
package iit_pkg;

  localparam int VAL_W  = 20;
  localparam int RSUM_W = 14;
  localparam int DIM_W  = 7;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam logic       CMD_PIXEL   = 1'b0;
  localparam logic       CMD_QUERY   = 1'b1;
  localparam logic [6:0] DIM_RESET   = 7'd64;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_ACCUM,
    ST_DELIVER
  } back_state_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] intensity;
    logic [5:0] left_x;
    logic [5:0] top_y;
    logic [6:0] right_x;
    logic [6:0] bottom_y;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             kind;
    logic             error;
  } result_t;

  typedef struct packed {
    logic       cmd;
    logic       bad;
    logic [7:0] intensity;
    logic [5:0] left_x;
    logic [5:0] top_y;
    logic [6:0] right_x;
    logic [6:0] bottom_y;
  } job_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

endpackage

>>> sv/iit_front.sv
// ----------------------------------------------------------------------------
// iit_front: configuration and item classification
// Holds the frame size registers, clamps them to the range 1 to the table size
// and tags each accepted item; bad queries are flagged here.
// ----------------------------------------------------------------------------
module iit_front import iit_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_e cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  item_t      item,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_entry,
  output dims_t      dims
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  assign dims.width  = clamp_dim(frame_width, MAX_WIDTH);
  assign dims.height = clamp_dim(frame_height, MAX_HEIGHT);

  logic bad_rect;
  always_comb begin
    bad_rect = (item.right_x <= {1'b0, item.left_x}) ||
               (item.bottom_y <= {1'b0, item.top_y}) ||
               (item.right_x > dims.width) ||
               (item.bottom_y > dims.height);
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_entry.cmd       = item.cmd;
    q_entry.bad       = (item.cmd == CMD_QUERY) && bad_rect;
    q_entry.intensity = item.intensity;
    q_entry.left_x    = item.left_x;
    q_entry.top_y     = item.top_y;
    q_entry.right_x   = item.right_x;
    q_entry.bottom_y  = item.bottom_y;
  end

endmodule

>>> sv/iit_queue.sv
// ----------------------------------------------------------------------------
// iit_queue: two-entry job queue
// Decouples classification from execution so either side can stall.
// ----------------------------------------------------------------------------
module iit_queue import iit_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t entry_in,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t entry_out
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  job_t            slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full      = (count == (PW+1)'(DEPTH));
  assign empty     = (count == '0);
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

>>> sv/iit_back.sv
// ----------------------------------------------------------------------------
// iit_back: table memory and execution sequencer
// Runs one job at a time against the table's single read port: pixels read the
// entry above and write back, queries read four corners and accumulate.
// ----------------------------------------------------------------------------
module iit_back import iit_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  dims_t   dims,
  input  logic    q_empty,
  input  job_t    q_head,
  output logic    q_pop,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);

  back_state_e state;
  back_state_e state_next;

  job_t              job;
  logic [1:0]        rd_idx;
  logic [VAL_W-1:0]  acc;
  logic [VAL_W-1:0]  res_value;
  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [RSUM_W-1:0] rsum;
  logic              out_valid;
  result_t           out_reg;

  logic [VAL_W-1:0]  table_mem [DEPTH];
  logic [VAL_W-1:0]  rd_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic              mem_we;
  logic              deliver;

  logic [RSUM_W-1:0] rsum_new;
  logic [VAL_W-1:0]  pix_value;
  logic [1:0]        acc_idx;
  logic [VAL_W-1:0]  acc_new;

  function automatic logic [AW-1:0] addr_of(int r, int c);
    return AW'(r * MAX_WIDTH + c);
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr] <= pix_value;
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = q_head.bad ? ST_DELIVER : ST_READ;
        end
      end
      ST_READ: begin
        if (job.cmd == CMD_PIXEL) begin
          state_next = ST_WRITE;
        end else if (rd_idx == 2'd3) begin
          state_next = ST_ACCUM;
        end
      end
      ST_WRITE:   state_next = ST_DELIVER;
      ST_ACCUM:   state_next = ST_DELIVER;
      ST_DELIVER: begin
        if (!out_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = (state == ST_IDLE) && !q_empty;
    rd_en   = (state == ST_READ);
    mem_we  = (state == ST_WRITE);
    deliver = (state == ST_DELIVER) && (!out_valid || pop);
  end

  always_comb begin
    if (job.cmd == CMD_PIXEL) begin
      rd_addr = (row != '0) ? addr_of(32'(row) - 1, 32'(col)) : '0;
    end else begin
      unique case (rd_idx)
        2'd0: rd_addr = addr_of(32'(job.bottom_y) - 1, 32'(job.right_x) - 1);
        2'd1: rd_addr = addr_of(32'(job.bottom_y) - 1, 32'(job.left_x));
        2'd2: rd_addr = addr_of(32'(job.top_y), 32'(job.right_x) - 1);
        2'd3: rd_addr = addr_of(32'(job.top_y), 32'(job.left_x));
      endcase
    end
    wr_addr   = addr_of(32'(row), 32'(col));
    rsum_new  = rsum + RSUM_W'(job.intensity);
    pix_value = VAL_W'(rsum_new) + ((row != '0) ? rd_data : '0);
    acc_idx   = (state == ST_ACCUM) ? 2'd3 : rd_idx - 2'd1;
    acc_new   = (acc_idx == 2'd0 || acc_idx == 2'd3) ? acc + rd_data : acc - rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_idx    <= '0;
      col       <= '0;
      row       <= '0;
      rsum      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (state == ST_READ) begin
        rd_idx <= rd_idx + 2'd1;
      end else if (q_pop) begin
        rd_idx <= '0;
      end
      if (mem_we) begin
        if (32'(col) + 1 >= 32'(dims.width)) begin
          col  <= '0;
          rsum <= '0;
          if (32'(row) + 1 >= 32'(dims.height)) begin
            row <= '0;
          end else begin
            row <= row + RW'(1);
          end
        end else begin
          col  <= col + CW'(1);
          rsum <= rsum_new;
          if (32'(row) >= 32'(dims.height)) begin
            row <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job       <= q_head;
      acc       <= '0;
      res_value <= '0;
    end
    if (state == ST_READ && job.cmd == CMD_QUERY && rd_idx != 2'd0) begin
      acc <= acc_new;
    end
    if (state == ST_ACCUM) begin
      res_value <= acc_new;
    end
    if (mem_we) begin
      res_value <= pix_value;
    end
    if (deliver) begin
      out_reg.value <= res_value;
      out_reg.kind  <= job.cmd;
      out_reg.error <= job.bad;
    end
  end

  assign empty  = !out_valid;
  assign result = out_reg;

endmodule

>>> sv/integral_image_table.sv
// The back-end sequencer runs one job at a time on the single read port of the table
// memory: a pixel reads and writes, a query reads its four corners and accumulates,
// and a bad query goes straight to delivery; new transactions queue meanwhile.
// While a result waits to be popped, up to three more transactions are accepted.
// Reset (rst, synchronous): clears queues, raster position and row sum; frame size
// returns to 64 x 64; table contents are left undefined until written.
// ----------------------------------------------------------------------------
// integral_image_table: summed-area table builder with rectangle queries
// Front end classifies transactions, a short queue feeds the back end that
// owns the table memory and the result register.
// ----------------------------------------------------------------------------
module integral_image_table import iit_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_e cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  item_t      item,
  output logic       empty,
  input  logic       pop,
  output result_t    result
);

  logic  q_full;
  logic  q_push;
  logic  q_empty;
  logic  q_pop;
  job_t  q_entry;
  job_t  q_head;
  dims_t dims;

  iit_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .item     (item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry),
    .dims     (dims)
  );

  iit_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .entry_in (q_entry),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .entry_out(q_head)
  );

  iit_back u_back (
    .clk    (clk),
    .rst    (rst),
    .dims   (dims),
    .q_empty(q_empty),
    .q_head (q_head),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for integral_image_table
// Streams raster pixels and rectangle queries through the push/full side,
// drains results through empty/pop with random stalls on both sides, and
// compares every result with a directed value or a summed-area predictor that
// tracks which table entries are written. Frame size is changed only when idle.
// ----------------------------------------------------------------------------
module tb;
  import iit_pkg::*;

  localparam int TBL_COLS     = 64;
  localparam int TBL_ROWS     = 64;
  localparam int RANDOM_ITEMS = 950;
  localparam int SETTLE_CYC   = 12;
  localparam int CYCLE_LIMIT  = 500000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    cfg_index_e reg_sel;
    logic [6:0] reg_val;
    item_t      it;
    bit         exact;
    result_t    want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_e cfg_index;
  logic [6:0] cfg_data;
  logic       push;
  logic       full;
  item_t      item;
  logic       empty;
  logic       pop;
  result_t    result;

  integral_image_table dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // predictor state
  logic [19:0] sat_mem [0:TBL_ROWS*TBL_COLS-1];
  bit          sat_written [0:TBL_ROWS*TBL_COLS-1];
  int          col_pos;
  int          row_pos;
  logic [13:0] row_sum;
  logic [6:0]  width_raw;
  logic [6:0]  height_raw;

  result_t     pending_results [$];
  stim_row_t   plan [$];
  int          mismatch_count;
  int unsigned cycle_count;
  bit          tx_idle;
  bit          rx_idle;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int eff_dim(logic [6:0] raw);
    if (raw == 0) return 1;
    if (raw > 64) return 64;
    return int'(raw);
  endfunction

  function automatic bit query_bad(item_t it);
    int w;
    int h;
    w = eff_dim(width_raw);
    h = eff_dim(height_raw);
    return (it.right_x <= it.left_x) || (it.bottom_y <= it.top_y) ||
           (int'(it.right_x) > w) || (int'(it.bottom_y) > h);
  endfunction

  function automatic int cell_idx(int row, int col);
    return row * TBL_COLS + col;
  endfunction

  // a good query touches only its four corners
  function automatic bit query_safe(item_t it);
    int l;
    int t;
    int r;
    int b;
    if (query_bad(it)) return 1'b1;
    l = it.left_x;
    t = it.top_y;
    r = int'(it.right_x) - 1;
    b = int'(it.bottom_y) - 1;
    return sat_written[cell_idx(b, r)] && sat_written[cell_idx(b, l)] &&
           sat_written[cell_idx(t, r)] && sat_written[cell_idx(t, l)];
  endfunction

  function automatic result_t sat_predict(item_t it);
    int          w;
    int          h;
    int          c;
    int          r;
    int          nc;
    int          nr;
    int          l;
    int          t;
    int          rx;
    int          by;
    logic [19:0] v;
    result_t     res;
    w = eff_dim(width_raw);
    h = eff_dim(height_raw);
    res = '0;
    if (it.cmd == CMD_PIXEL) begin
      c = col_pos;
      r = row_pos;
      row_sum = row_sum + it.intensity;
      v = 20'(row_sum);
      if (r > 0) v = v + sat_mem[cell_idx(r - 1, c)];
      sat_mem[cell_idx(r, c)] = v;
      sat_written[cell_idx(r, c)] = 1'b1;
      nc = c + 1;
      nr = r;
      if (nc >= w) begin
        nc = 0;
        row_sum = '0;
        nr = r + 1;
        if (nr >= h) nr = 0;
      end else if (nr >= h) begin
        nr = 0;
      end
      col_pos = nc;
      row_pos = nr;
      res.value = v;
      res.kind = CMD_PIXEL;
    end else begin
      res.kind = CMD_QUERY;
      if (query_bad(it)) begin
        res.error = 1'b1;
      end else begin
        l = it.left_x;
        t = it.top_y;
        rx = int'(it.right_x) - 1;
        by = int'(it.bottom_y) - 1;
        res.value = sat_mem[cell_idx(by, rx)] - sat_mem[cell_idx(by, l)]
                  - sat_mem[cell_idx(t, rx)] + sat_mem[cell_idx(t, l)];
      end
    end
    return res;
  endfunction

  function automatic item_t pixel_item(logic [7:0] intensity);
    item_t it;
    it = item_t'({$urandom, $urandom});
    it.cmd = CMD_PIXEL;
    it.intensity = intensity;
    return it;
  endfunction

  function automatic item_t query_item(int l, int t, int r, int b);
    item_t it;
    it.cmd = CMD_QUERY;
    it.intensity = 8'($urandom);
    it.left_x = 6'(l);
    it.top_y = 6'(t);
    it.right_x = 7'(r);
    it.bottom_y = 7'(b);
    return it;
  endfunction

  function automatic stim_row_t row_item(item_t it, bit exact, logic [19:0] v, logic err);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.reg_sel = CFG_FRAME_WIDTH;
    row.reg_val = '0;
    row.it = it;
    row.exact = exact;
    row.want.value = v;
    row.want.kind = it.cmd;
    row.want.error = err;
    return row;
  endfunction

  function automatic stim_row_t row_cfg(cfg_index_e sel, logic [6:0] val);
    stim_row_t row;
    row = row_item(pixel_item(8'd0), 1'b0, '0, 1'b0);
    row.kind = ROW_CFG;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // random query; one whose corners are not yet written is turned into an empty rect
  function automatic item_t random_query(bit well_formed);
    int    w;
    int    h;
    int    l;
    int    t;
    item_t it;
    w = eff_dim(width_raw);
    h = eff_dim(height_raw);
    if (well_formed) begin
      l = $urandom_range(0, w - 1);
      t = $urandom_range(0, h - 1);
      it = query_item(l, t, $urandom_range(l + 1, w), $urandom_range(t + 1, h));
    end else begin
      it = query_item($urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 64), $urandom_range(0, 64));
    end
    if (!query_safe(it)) it.right_x = 7'(it.left_x);
    return it;
  endfunction

  task automatic send_item(item_t it, bit exact, result_t want);
    int      gap;
    result_t res;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full !== 1'b0);
    res = sat_predict(it);
    pending_results.push_back(exact ? want : res);
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_e sel, logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (sel == CFG_FRAME_WIDTH) width_raw = val;
    else height_raw = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side
  initial begin : result_sink
    int      gap;
    result_t exp_r;
    wait (rst === 1'b0);
    forever begin
      gap = rx_idle ? $urandom_range(0, 19) : 0;
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: value %0d kind %0d error %0d",
               result.value, result.kind, result.error);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result.value !== exp_r.value) begin
          $error("value: expected %0d, got %0d", exp_r.value, result.value);
          mismatch_count++;
        end
        if (result.kind !== exp_r.kind) begin
          $error("kind: expected %0d, got %0d", exp_r.kind, result.kind);
          mismatch_count++;
        end
        if (result.error !== exp_r.error) begin
          $error("error: expected %0d, got %0d", exp_r.error, result.error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int      total;
    int      n;
    int      target;
    int      sel;
    bit      w_first;
    logic [6:0] w_val;
    logic [6:0] h_val;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    item = '0;
    mismatch_count = 0;
    cycle_count = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    col_pos = 0;
    row_pos = 0;
    row_sum = '0;
    width_raw = DIM_RESET;
    height_raw = DIM_RESET;
    foreach (sat_written[i]) sat_written[i] = 1'b0;
    foreach (sat_mem[i]) sat_mem[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    plan.push_back(row_item(query_item(0, 0, 0, 0), 1'b1, 20'd0, 1'b1));
    plan.push_back(row_cfg(CFG_FRAME_WIDTH, 7'd2));
    plan.push_back(row_cfg(CFG_FRAME_HEIGHT, 7'd2));
    plan.push_back(row_item(pixel_item(8'd255), 1'b1, 20'd255, 1'b0));
    plan.push_back(row_item(pixel_item(8'd255), 1'b1, 20'd510, 1'b0));
    plan.push_back(row_item(pixel_item(8'd255), 1'b1, 20'd510, 1'b0));
    plan.push_back(row_item(pixel_item(8'd255), 1'b1, 20'd1020, 1'b0));
    plan.push_back(row_item(query_item(0, 0, 2, 2), 1'b1, 20'd255, 1'b0));
    plan.push_back(row_item(query_item(1, 1, 2, 2), 1'b1, 20'd0, 1'b0));
    plan.push_back(row_item(query_item(63, 63, 64, 64), 1'b1, 20'd0, 1'b1));
    plan.push_back(row_item(query_item(0, 1, 1, 1), 1'b1, 20'd0, 1'b1));
    // oversize width saturates, zero height acts as one row
    plan.push_back(row_cfg(CFG_FRAME_WIDTH, 7'd127));
    plan.push_back(row_cfg(CFG_FRAME_HEIGHT, 7'd0));
    plan.push_back(row_item(pixel_item(8'd0), 1'b1, 20'd0, 1'b0));
    plan.push_back(row_item(pixel_item(8'd255), 1'b1, 20'd255, 1'b0));
    plan.push_back(row_item(query_item(0, 0, 2, 1), 1'b0, '0, 1'b0));
    // width shrinks below the current column in mid-row
    plan.push_back(row_cfg(CFG_FRAME_WIDTH, 7'd0));
    plan.push_back(row_item(pixel_item(8'd7), 1'b0, '0, 1'b0));
    plan.push_back(row_item(pixel_item(8'd9), 1'b0, '0, 1'b0));
    plan.push_back(row_cfg(CFG_FRAME_WIDTH, 7'd4));
    plan.push_back(row_cfg(CFG_FRAME_HEIGHT, 7'd2));
    for (int i = 1; i <= 8; i++) plan.push_back(row_item(pixel_item(8'(i * 31)), 1'b0, '0, 1'b0));
    plan.push_back(row_item(query_item(0, 0, 4, 2), 1'b0, '0, 1'b0));
    plan.push_back(row_item(query_item(2, 0, 4, 2), 1'b0, '0, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        send_item(plan[i].it, plan[i].exact, plan[i].want);
      end
    end

    // random phases; each starts and ends at the frame origin
    total = 0;
    while (total < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: begin
          w_val = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'($urandom_range(65, 127));
          h_val = 7'($urandom_range(1, 3));
        end
        1: begin
          w_val = 7'($urandom_range(0, 1));
          h_val = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'($urandom_range(65, 127));
        end
        2: begin
          w_val = 7'($urandom_range(0, 1));
          h_val = 7'($urandom_range(0, 1));
        end
        default: begin
          w_val = 7'($urandom_range(1, 10));
          h_val = 7'($urandom_range(1, 10));
        end
      endcase
      drain();
      w_first = $urandom_range(0, 1);
      if (w_first) write_reg(CFG_FRAME_WIDTH, w_val);
      write_reg(CFG_FRAME_HEIGHT, h_val);
      if (!w_first) write_reg(CFG_FRAME_WIDTH, w_val);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);

      target = $urandom_range(15, 90);
      n = 0;
      while (n < target || col_pos != 0 || row_pos != 0) begin
        if ($urandom_range(0, 3) == 0)
          send_item(random_query($urandom_range(0, 4) != 0), 1'b0, '0);
        else
          send_item(pixel_item(8'($urandom)), 1'b0, '0);
        n++;
        total++;
        if ($urandom_range(0, 59) == 0) drain();
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/iit_pkg.sv
sv/iit_front.sv
sv/iit_queue.sv
sv/iit_back.sv
sv/integral_image_table.sv
tb/sv/tb.sv
